// ===== sv/segtri_pkg.sv =====
// shared constants for the segment triangle intersection core
`default_nettype none
package segtri_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_QUERY = 1'b1;
   localparam int PLANE_LAT = 8;
   localparam int FACE_LAT = 9;
endpackage
`default_nettype wire

// ===== sv/segtri_delay.sv =====
// enabled shift line that delays a payload word by a fixed number of stages
`default_nettype none
module segtri_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign dout = stage_ff[DEPTH-1];
endmodule
`default_nettype wire

// ===== sv/segtri_mul.sv =====
// two stage signed multiplier split into four partial products
`default_nettype none
module segtri_mul #(
   parameter int A_WIDTH = 33,
   parameter int B_WIDTH = 33
) (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic signed [A_WIDTH-1:0]         a,
   input  wire logic signed [B_WIDTH-1:0]         b,
   output logic signed [A_WIDTH+B_WIDTH-1:0]      prod
);
   localparam int ALO = A_WIDTH / 2;
   localparam int AHI = A_WIDTH - ALO;
   localparam int BLO = B_WIDTH / 2;
   localparam int BHI = B_WIDTH - BLO;
   localparam int PW = A_WIDTH + B_WIDTH;

   logic signed [AHI-1:0] a_hi;
   logic signed [ALO:0] a_lo;
   logic signed [BHI-1:0] b_hi;
   logic signed [BLO:0] b_lo;
   logic signed [AHI+BHI-1:0] hh_ff;
   logic signed [AHI+BLO:0] hl_ff;
   logic signed [ALO+BHI:0] lh_ff;
   logic signed [ALO+BLO+1:0] ll_ff;
   logic signed [PW-1:0] prod_ff;

   assign a_hi = a[A_WIDTH-1:ALO];
   assign a_lo = {1'b0, a[ALO-1:0]};
   assign b_hi = b[B_WIDTH-1:BLO];
   assign b_lo = {1'b0, b[BLO-1:0]};

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= a_hi * b_hi;
         hl_ff <= a_hi * b_lo;
         lh_ff <= a_lo * b_hi;
         ll_ff <= a_lo * b_lo;
         prod_ff <= (PW'(hh_ff) <<< (ALO + BLO)) + (PW'(hl_ff) <<< ALO)
                    + (PW'(lh_ff) <<< BLO) + PW'(ll_ff);
      end
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

// ===== sv/segtri_plane.sv =====
// face normal and signed plane distances of both edge ends
`default_nettype none
module segtri_plane #(
   parameter int CW = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 en,
   input  wire logic [2:0][CW-1:0]                   a,
   input  wire logic [2:0][CW-1:0]                   b,
   input  wire logic [2:0][2:0][CW-1:0]              p,
   output logic [2:0][2*(CW+1)+1-1:0]                n_out,
   output logic [2*(CW+1)+1+(CW+1)+3-1:0]            num,
   output logic [2*(CW+1)+1+(CW+1)+3-1:0]            den,
   output logic                                      crossed,
   output logic [2:0][CW-1:0]                        a_out,
   output logic [2:0][CW:0]                          v_out,
   output logic [2:0][2:0][CW-1:0]                   p_out
);
   localparam int DW = CW + 1;
   localparam int NW = 2 * DW + 1;
   localparam int SW = NW + DW + 2;
   localparam int DENW = SW + 1;

   logic [2:0][DW-1:0] e1_ff, e2_ff, da_ff, db_ff, v_ff;
   logic [2:0][DW-1:0] da_d, db_d;
   logic [2:0][NW-1:0] n_ff;
   logic signed [2*DW-1:0] cp_pos [3];
   logic signed [2*DW-1:0] cp_neg [3];
   logic signed [NW+DW-1:0] dot_a [3];
   logic signed [NW+DW-1:0] dot_b [3];
   logic signed [SW-1:0] sa_ff, sb_ff;
   logic signed [DENW-1:0] sa_ext, diff;
   logic [DENW-1:0] num_ff, den_ff;
   logic crossed_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= DW'($signed(p[1][i])) - DW'($signed(p[0][i]));
            e2_ff[i] <= DW'($signed(p[2][i])) - DW'($signed(p[0][i]));
            da_ff[i] <= DW'($signed(a[i])) - DW'($signed(p[0][i]));
            db_ff[i] <= DW'($signed(b[i])) - DW'($signed(p[0][i]));
            v_ff[i] <= DW'($signed(b[i])) - DW'($signed(a[i]));
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_normal
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      segtri_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_pos (
         .clock(clock), .en(en), .a($signed(e1_ff[J])), .b($signed(e2_ff[K])),
         .prod(cp_pos[i])
      );
      segtri_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_neg (
         .clock(clock), .en(en), .a($signed(e1_ff[K])), .b($signed(e2_ff[J])),
         .prod(cp_neg[i])
      );
   end

   segtri_delay #(.WIDTH(6 * DW), .DEPTH(3)) u_dist_dly (
      .clock(clock), .en(en), .din({da_ff, db_ff}), .dout({da_d, db_d})
   );

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= NW'(cp_pos[i]) - NW'(cp_neg[i]);
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_dot
      segtri_mul #(.A_WIDTH(NW), .B_WIDTH(DW)) u_sa (
         .clock(clock), .en(en), .a($signed(n_ff[i])), .b($signed(da_d[i])),
         .prod(dot_a[i])
      );
      segtri_mul #(.A_WIDTH(NW), .B_WIDTH(DW)) u_sb (
         .clock(clock), .en(en), .a($signed(n_ff[i])), .b($signed(db_d[i])),
         .prod(dot_b[i])
      );
   end

   assign sa_ext = DENW'(sa_ff);
   assign diff = sa_ext - DENW'(sb_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff <= SW'(dot_a[0]) + SW'(dot_a[1]) + SW'(dot_a[2]);
         sb_ff <= SW'(dot_b[0]) + SW'(dot_b[1]) + SW'(dot_b[2]);
         crossed_ff <= sa_ff[SW-1] ^ sb_ff[SW-1];
         num_ff <= sa_ff[SW-1] ? -sa_ext : sa_ext;
         den_ff <= diff[DENW-1] ? -diff : diff;
      end
   end

   segtri_delay #(.WIDTH(3 * NW), .DEPTH(4)) u_n_dly (
      .clock(clock), .en(en), .din(n_ff), .dout(n_out)
   );
   segtri_delay #(.WIDTH(12 * CW), .DEPTH(8)) u_ap_dly (
      .clock(clock), .en(en), .din({a, p}), .dout({a_out, p_out})
   );
   segtri_delay #(.WIDTH(3 * DW), .DEPTH(7)) u_v_dly (
      .clock(clock), .en(en), .din(v_ff), .dout(v_out)
   );

   assign num = num_ff;
   assign den = den_ff;
   assign crossed = crossed_ff;
endmodule
`default_nettype wire

// ===== sv/segtri_div.sv =====
// restoring divider pipeline, one quotient bit per stage
`default_nettype none
module segtri_div #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic [2*(CW+1)+1+(CW+1)+3-1:0]      num,
   input  wire logic [2*(CW+1)+1+(CW+1)+3-1:0]      den,
   input  wire logic                                crossed,
   output logic [FB:0]                              tq,
   output logic                                     crossed_out
);
   localparam int DW = CW + 1;
   localparam int NW = 2 * DW + 1;
   localparam int DENW = NW + DW + 3;
   localparam int RW = DENW + 1;

   logic [RW-1:0] rem_ff [FB+1];
   logic [DENW-1:0] den_ff [FB+1];
   logic [FB:0] quo_ff [FB+1];
   logic cross_ff [FB+1];

   for (genvar k = 0; k <= FB; k++) begin : g_step
      logic [RW-1:0] rem_w;
      logic [DENW-1:0] den_w;
      logic [FB:0] quo_w;
      logic cross_w;
      logic ge;
      if (k == 0) begin : g_first
         assign rem_w = RW'(num);
         assign den_w = den;
         assign quo_w = '0;
         assign cross_w = crossed;
      end else begin : g_next
         assign rem_w = {rem_ff[k-1][RW-2:0], 1'b0};
         assign den_w = den_ff[k-1];
         assign quo_w = quo_ff[k-1];
         assign cross_w = cross_ff[k-1];
      end
      assign ge = rem_w >= RW'(den_w);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? rem_w - RW'(den_w) : rem_w;
            den_ff[k] <= den_w;
            quo_ff[k] <= (FB+1)'({quo_w, ge});
            cross_ff[k] <= cross_w;
         end
      end
   end

   assign tq = quo_ff[FB];
   assign crossed_out = cross_ff[FB];
endmodule
`default_nettype wire

// ===== sv/segtri_face.sv =====
// crossing point and the edge half-plane tests of the triangular face
`default_nettype none
module segtri_face #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [FB:0]                   tq,
   input  wire logic                          crossed,
   input  wire logic [2:0][CW-1:0]            a,
   input  wire logic [2:0][CW:0]              v,
   input  wire logic [2:0][2:0][CW-1:0]       p,
   input  wire logic [2:0][2*(CW+1):0]        n,
   output logic                               hit,
   output logic [2:0][CW-1:0]                 x_out
);
   localparam int DW = CW + 1;
   localparam int NW = 2 * DW + 1;
   localparam int PRW = DW + FB + 2;
   localparam int XW = PRW + 1;
   localparam int FW = 2 * NW + 2;
   localparam logic signed [XW-1:0] XMAX = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [XW-1:0] XMIN = {{(XW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   logic signed [PRW-1:0] prod_ff [3];
   logic [2:0][CW-1:0] a_ff;
   logic cross1_ff, cross9;
   logic [2:0][CW-1:0] x_ff;
   logic [2:0][2:0][CW-1:0] p_d;
   logic [2:0][2:0][DW-1:0] d2x_ff, d23_ff;
   logic [2:0][2:0][NW-1:0] cx_ff;
   logic [2:0][NW-1:0] n_d;
   logic signed [2*DW-1:0] cp_pos [3][3];
   logic signed [2*DW-1:0] cp_neg [3][3];
   logic signed [2*NW-1:0] dp [3][3];
   logic signed [XW-1:0] xsum [3];
   logic signed [FW-1:0] dsum [3];
   logic hit_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= $signed(v[i]) * $signed({1'b0, tq});
         end
         a_ff <= a;
         cross1_ff <= crossed;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xsum[i] = XW'($signed(a_ff[i])) + XW'(prod_ff[i] >>> FB);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (!cross1_ff) begin
               x_ff[i] <= '0;
            end else if (xsum[i] > XMAX) begin
               x_ff[i] <= CW'(XMAX);
            end else if (xsum[i] < XMIN) begin
               x_ff[i] <= CW'(XMIN);
            end else begin
               x_ff[i] <= CW'(xsum[i]);
            end
         end
      end
   end

   segtri_delay #(.WIDTH(9 * CW), .DEPTH(2)) u_p_dly (
      .clock(clock), .en(en), .din(p), .dout(p_d)
   );

   for (genvar r = 0; r < 3; r++) begin : g_rot
      localparam int Q2 = (r == 0) ? 1 : ((r == 1) ? 0 : 2);
      localparam int Q3 = (r == 0) ? 2 : ((r == 1) ? 1 : 0);
      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               d2x_ff[r][i] <= DW'($signed(x_ff[i])) - DW'($signed(p_d[Q2][i]));
               d23_ff[r][i] <= DW'($signed(p_d[Q3][i])) - DW'($signed(p_d[Q2][i]));
            end
         end
      end
      for (genvar i = 0; i < 3; i++) begin : g_axis
         localparam int J = (i + 1) % 3;
         localparam int K = (i + 2) % 3;
         segtri_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_pos (
            .clock(clock), .en(en), .a($signed(d2x_ff[r][J])),
            .b($signed(d23_ff[r][K])), .prod(cp_pos[r][i])
         );
         segtri_mul #(.A_WIDTH(DW), .B_WIDTH(DW)) u_neg (
            .clock(clock), .en(en), .a($signed(d2x_ff[r][K])),
            .b($signed(d23_ff[r][J])), .prod(cp_neg[r][i])
         );
         always_ff @(posedge clock) begin
            if (en) begin
               cx_ff[r][i] <= NW'(cp_pos[r][i]) - NW'(cp_neg[r][i]);
            end
         end
         segtri_mul #(.A_WIDTH(NW), .B_WIDTH(NW)) u_dot (
            .clock(clock), .en(en), .a($signed(n_d[i])), .b($signed(cx_ff[r][i])),
            .prod(dp[r][i])
         );
      end
      assign dsum[r] = FW'(dp[r][0]) + FW'(dp[r][1]) + FW'(dp[r][2]);
   end

   segtri_delay #(.WIDTH(3 * NW), .DEPTH(6)) u_n_dly (
      .clock(clock), .en(en), .din(n), .dout(n_d)
   );
   segtri_delay #(.WIDTH(1), .DEPTH(7)) u_cross_dly (
      .clock(clock), .en(en), .din(cross1_ff), .dout(cross9)
   );
   segtri_delay #(.WIDTH(3 * CW), .DEPTH(7)) u_x_dly (
      .clock(clock), .en(en), .din(x_ff), .dout(x_out)
   );

   // face normal points opposite to each edge test normal, so inside means <= 0
   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= cross9 && (dsum[0][FW-1] || dsum[0] == '0)
                   && (dsum[1][FW-1] || dsum[1] == '0)
                   && (dsum[2][FW-1] || dsum[2] == '0);
      end
   end

   assign hit = hit_ff;
endmodule
`default_nettype wire

// ===== sv/segment_triangle_intersection_core.sv =====
// throughput: one item per cycle while the output buffer has room, set by the
// fully pipelined divider and multipliers
// loads update the vertex store at transfer and give no result
// two-entry output buffer keeps the pipeline moving while a result waits
// reset (synchronous, active high) clears the vertex store, valid bits and buffer
`default_nettype none
module segment_triangle_intersection_core import segtri_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_opcode,
   input  wire logic [1:0]             req_slot,
   input  wire logic [COORD_WIDTH-1:0] req_point_a_x,
   input  wire logic [COORD_WIDTH-1:0] req_point_a_y,
   input  wire logic [COORD_WIDTH-1:0] req_point_a_z,
   input  wire logic [COORD_WIDTH-1:0] req_point_b_x,
   input  wire logic [COORD_WIDTH-1:0] req_point_b_y,
   input  wire logic [COORD_WIDTH-1:0] req_point_b_z,
   input  wire logic [1:0]             req_face_second,
   input  wire logic [1:0]             req_face_third,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_hit,
   output logic [COORD_WIDTH-1:0]      rsp_cross_x,
   output logic [COORD_WIDTH-1:0]      rsp_cross_y,
   output logic [COORD_WIDTH-1:0]      rsp_cross_z
);
   localparam int CW = COORD_WIDTH;
   localparam int DW = CW + 1;
   localparam int NW = 2 * DW + 1;
   localparam int DENW = NW + DW + 3;
   localparam int LAT = 1 + PLANE_LAT + FRAC_BITS + 1 + FACE_LAT;
   localparam int SBW = 3 * CW + 3 * DW + 9 * CW + 3 * NW;
   localparam int OW = 3 * CW + 1;

   logic [CW-1:0] vert_x_ff [4];
   logic [CW-1:0] vert_y_ff [4];
   logic [CW-1:0] vert_z_ff [4];
   logic [2:0][1:0] idx;
   logic [2:0][CW-1:0] a_ff, b_ff;
   logic [2:0][2:0][CW-1:0] p_ff;
   logic [LAT-1:0] vld_ff;
   logic adv, accept, push, pop;
   logic [1:0] skid_count_ff;
   logic [OW-1:0] skid_ff [2];
   logic [OW-1:0] out_word;

   logic [2:0][NW-1:0] pl_n, dv_n;
   logic [DENW-1:0] pl_num, pl_den;
   logic pl_crossed, dv_crossed;
   logic [2:0][CW-1:0] pl_a, dv_a;
   logic [2:0][DW-1:0] pl_v, dv_v;
   logic [2:0][2:0][CW-1:0] pl_p, dv_p;
   logic [FRAC_BITS:0] dv_tq;
   logic fc_hit;
   logic [2:0][CW-1:0] fc_x;

   assign adv = skid_count_ff != 2'd2;
   assign req_stall = !adv;
   assign accept = req_valid && adv;
   assign idx = {req_face_third, req_face_second, req_slot};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            vert_x_ff[i] <= '0;
            vert_y_ff[i] <= '0;
            vert_z_ff[i] <= '0;
         end
      end else if (accept && req_opcode == OP_LOAD) begin
         vert_x_ff[req_slot] <= req_point_a_x;
         vert_y_ff[req_slot] <= req_point_a_y;
         vert_z_ff[req_slot] <= req_point_a_z;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= {req_point_a_z, req_point_a_y, req_point_a_x};
         b_ff <= {req_point_b_z, req_point_b_y, req_point_b_x};
         for (int k = 0; k < 3; k++) begin
            p_ff[k] <= {vert_z_ff[idx[k]], vert_y_ff[idx[k]], vert_x_ff[idx[k]]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], accept && req_opcode == OP_QUERY};
      end
   end

   segtri_plane #(.CW(CW)) u_plane (
      .clock(clock), .en(adv), .a(a_ff), .b(b_ff), .p(p_ff),
      .n_out(pl_n), .num(pl_num), .den(pl_den), .crossed(pl_crossed),
      .a_out(pl_a), .v_out(pl_v), .p_out(pl_p)
   );

   segtri_div #(.CW(CW), .FB(FRAC_BITS)) u_div (
      .clock(clock), .en(adv), .num(pl_num), .den(pl_den), .crossed(pl_crossed),
      .tq(dv_tq), .crossed_out(dv_crossed)
   );

   segtri_delay #(.WIDTH(SBW), .DEPTH(FRAC_BITS + 1)) u_side_dly (
      .clock(clock), .en(adv), .din({pl_a, pl_v, pl_p, pl_n}),
      .dout({dv_a, dv_v, dv_p, dv_n})
   );

   segtri_face #(.CW(CW), .FB(FRAC_BITS)) u_face (
      .clock(clock), .en(adv), .tq(dv_tq), .crossed(dv_crossed), .a(dv_a),
      .v(dv_v), .p(dv_p), .n(dv_n), .hit(fc_hit), .x_out(fc_x)
   );

   assign out_word = {fc_hit, fc_x};
   assign push = vld_ff[LAT-1] && adv;
   assign pop = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_count_ff <= '0;
      end else begin
         skid_count_ff <= skid_count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         skid_ff[0] <= (skid_count_ff == 2'd1) ? out_word : skid_ff[1];
      end else if (push && skid_count_ff == 2'd0) begin
         skid_ff[0] <= out_word;
      end
      if (push && (skid_count_ff == 2'd1) && !pop) begin
         skid_ff[1] <= out_word;
      end
   end

   assign rsp_valid = skid_count_ff != 2'd0;
   assign {rsp_hit, rsp_cross_z, rsp_cross_y, rsp_cross_x} = skid_ff[0];

   a_skid_bound: assert property (@(posedge clock) disable iff (reset)
      skid_count_ff != 2'd3)
      else $error("output buffer overflow");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (skid_count_ff == 2'd2) |-> (req_stall && !push))
      else $error("transfer into a full output buffer");

   a_load_write: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == OP_LOAD) |=>
      (vert_x_ff[$past(req_slot)] == $past(req_point_a_x)))
      else $error("vertex load not stored");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (skid_count_ff == $past(skid_count_ff) - 2'd1))
      else $error("buffer count wrong after transfer");
endmodule
`default_nettype wire
